@@ rtl/lmrf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmrf_pkg
// Shared widths, register indexes, reset values and the per-item control
// struct of the lane-marking row filter.
// ----------------------------------------------------------------------------
package lmrf_pkg;

	localparam int PIX_W = 8;
	localparam int COL_W = 12;
	localparam int DIM_W = 13;
	localparam int MW_W  = 6;
	localparam int CFG_W = 13;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH    = 2'd0,
		CFG_FRAME_HEIGHT   = 2'd1,
		CFG_MARKING_WIDTH  = 2'd2,
		CFG_EDGE_THRESHOLD = 2'd3
	} cfg_idx_t;

	// register reset values
	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST    = 13'd800;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST   = 13'd600;
	localparam logic [MW_W-1:0]  MARKING_WIDTH_RST  = 6'd10;
	localparam logic [PIX_W-1:0] EDGE_THRESHOLD_RST = 8'd40;

	localparam logic [PIX_W-1:0] MARK_ON  = 8'd255;
	localparam logic [PIX_W-1:0] MARK_OFF = 8'd0;

	// what one accepted pixel asks of the result sequencer
	typedef struct packed {
		logic             norm;       // one filtered result for column c - w
		logic             flush;      // row end: zero results up to column c
		logic             qual;       // filtered column is inside the valid area
		logic [COL_W-1:0] first_col;  // column of the first result
		logic [COL_W-1:0] last_col;   // column of the pixel itself
	} item_ctl_t;

endpackage

@@ rtl/lmrf_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmrf_pix_if / lmrf_res_if
// Valid/ready channels for input pixels and filter results.
// ----------------------------------------------------------------------------
interface lmrf_pix_if import lmrf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface lmrf_res_if import lmrf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] marked;
	logic [COL_W-1:0] out_column;
	logic             row_end;

	modport source (output valid, output marked, output out_column, output row_end,
		input ready);
	modport sink (input valid, input marked, input out_column, input row_end,
		output ready);
endinterface

@@ rtl/lmrf_window_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmrf_window_mem
// Circular pixel history. Each accepted pixel is written at the write
// pointer; the center (w back) and left (2w back) taps are read registered.
// ----------------------------------------------------------------------------
module lmrf_window_mem import lmrf_pkg::*; #(
	parameter int MAX_MARKING_WIDTH = 63
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [PIX_W-1:0] pixel,
	input  logic [MW_W-1:0]  mwidth,
	output logic [PIX_W-1:0] ctr_s1,
	output logic [PIX_W-1:0] lft_s1
);

	localparam int AW    = $clog2(2 * MAX_MARKING_WIDTH + 1);
	localparam int DEPTH = 2 ** AW;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    ctr_addr;
	logic [AW-1:0]    lft_addr;

	// tap addresses, mod the power-of-two depth
	assign ctr_addr = wptr_q - AW'(mwidth);
	assign lft_addr = wptr_q - AW'(mwidth) - AW'(mwidth);

	// write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
		end else if (take) begin
			wptr_q <= wptr_q + AW'(1);
		end
	end

	// storage with registered reads
	always_ff @(posedge clk) begin
		if (take) begin
			mem[wptr_q] <= pixel;
			ctr_s1      <= mem[ctr_addr];
			lft_s1      <= mem[lft_addr];
		end
	end

endmodule

@@ rtl/lmrf_pos_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmrf_pos_track
// Column and row counters. Decides, per accepted pixel, which results it
// causes and whether the filtered column lies inside the valid area.
// ----------------------------------------------------------------------------
module lmrf_pos_track import lmrf_pkg::*; #(
	parameter int MAX_COLUMNS = 4096,
	parameter int MAX_ROWS    = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic             frame_start,
	input  logic [DIM_W-1:0] frame_width,
	input  logic [DIM_W-1:0] frame_height,
	input  logic [MW_W-1:0]  mwidth,
	output item_ctl_t        ctl
);

	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] row_q;
	logic [COL_W-1:0] col_cur;
	logic [COL_W-1:0] row_cur;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [DIM_W-1:0] c13;
	logic [DIM_W-1:0] mw13;
	logic             row_end;
	logic             row_last;
	logic             lower;

	// saturate frame size
	always_comb begin
		if (frame_width == '0) begin
			w_eff = DIM_W'(1);
		end else if (frame_width > DIM_W'(MAX_COLUMNS)) begin
			w_eff = DIM_W'(MAX_COLUMNS);
		end else begin
			w_eff = frame_width;
		end
		if (frame_height == '0) begin
			h_eff = DIM_W'(1);
		end else if (frame_height > DIM_W'(MAX_ROWS)) begin
			h_eff = DIM_W'(MAX_ROWS);
		end else begin
			h_eff = frame_height;
		end
	end

	// position of the arriving pixel
	assign col_cur  = frame_start ? '0 : col_q;
	assign row_cur  = frame_start ? '0 : row_q;
	assign c13      = {1'b0, col_cur};
	assign mw13     = DIM_W'(mwidth);
	assign row_end  = c13 >= (w_eff - DIM_W'(1));
	assign row_last = {1'b0, row_cur} >= (h_eff - DIM_W'(1));
	assign lower    = {1'b0, row_cur} >= (h_eff >> 1);

	// results caused by this pixel
	always_comb begin
		ctl.norm      = c13 >= mw13;
		ctl.flush     = row_end;
		ctl.qual      = lower && (c13 >= (mw13 << 1)) && (c13 < w_eff);
		ctl.first_col = ctl.norm ? (col_cur - COL_W'(mwidth)) : '0;
		ctl.last_col  = col_cur;
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_cur + COL_W'(1);
			end else begin
				col_q <= col_cur + COL_W'(1);
				row_q <= row_cur;
			end
		end
	end

endmodule

@@ rtl/lmrf_emit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmrf_emit
// Item stage and result sequencer. Computes the dark-light-dark strength of
// the filtered column, then issues the normal result and any row-end flush
// results into the output register, one per cycle while it can load.
// ----------------------------------------------------------------------------
module lmrf_emit import lmrf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  item_ctl_t        ctl,
	input  logic [PIX_W-1:0] pixel,
	input  logic [PIX_W-1:0] ctr_s1,
	input  logic [PIX_W-1:0] lft_s1,
	input  logic [PIX_W-1:0] threshold,
	lmrf_res_if.source       res
);

	logic             norm_s1;
	logic             flush_s1;
	logic             qual_s1;
	logic [COL_W-1:0] k_s1;
	logic [COL_W-1:0] end_s1;
	logic [PIX_W-1:0] rgt_s1;

	logic             res_valid_q;
	logic [PIX_W-1:0] marked_q;
	logic [COL_W-1:0] column_q;
	logic             row_end_q;

	logic             busy;
	logic             at_end;
	logic             last_emit;
	logic             o_load;
	logic             fire;
	logic             take;
	logic [PIX_W-1:0] nb_max;
	logic [PIX_W:0]   diff;
	logic [PIX_W-1:0] strength;
	logic             mark;
	logic [PIX_W-1:0] emit_marked;
	logic             emit_end;

	// handshake control
	assign busy      = norm_s1 || flush_s1;
	assign at_end    = k_s1 == end_s1;
	assign last_emit = (norm_s1 && !flush_s1) || (!norm_s1 && flush_s1 && at_end);
	assign o_load    = !res_valid_q || res.ready;
	assign fire      = busy && o_load;
	assign in_ready  = !busy || (last_emit && o_load);
	assign take      = in_valid && in_ready;

	// strength 2*c - l - r - |l - r| = 2*(c - max(l, r)), clamped to 0..255
	always_comb begin
		nb_max = (lft_s1 > rgt_s1) ? lft_s1 : rgt_s1;
		diff   = {1'b0, ctr_s1} - {1'b0, nb_max};
		if (diff[PIX_W]) begin
			strength = '0;
		end else if (diff[PIX_W-1]) begin
			strength = '1;
		end else begin
			strength = {diff[PIX_W-2:0], 1'b0};
		end
		mark = qual_s1 && (ctr_s1 != '0) && (strength > threshold);
	end

	// result selection
	always_comb begin
		if (norm_s1) begin
			emit_marked = mark ? MARK_ON : MARK_OFF;
			emit_end    = 1'b0;
		end else begin
			emit_marked = MARK_OFF;
			emit_end    = at_end;
		end
	end

	// item stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_s1  <= 1'b0;
			flush_s1 <= 1'b0;
		end else if (take) begin
			norm_s1  <= ctl.norm;
			flush_s1 <= ctl.flush;
		end else if (fire) begin
			if (norm_s1) begin
				norm_s1 <= 1'b0;
			end else if (at_end) begin
				flush_s1 <= 1'b0;
			end
		end
	end

	// item payload and flush cursor
	always_ff @(posedge clk) begin
		if (take) begin
			qual_s1 <= ctl.qual;
			k_s1    <= ctl.first_col;
			end_s1  <= ctl.last_col;
			rgt_s1  <= pixel;
		end else if (fire && !(flush_s1 && !norm_s1 && at_end)) begin
			k_s1 <= k_s1 + COL_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (o_load) begin
			res_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			marked_q  <= emit_marked;
			column_q  <= k_s1;
			row_end_q <= emit_end;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.marked     = marked_q;
	assign res.out_column = column_q;
	assign res.row_end    = row_end_q;

`ifndef SYNTHESIS
	// an item with results still to come after this cycle holds off input
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !(last_emit && o_load) |-> !in_ready)
		else $error("input taken while results pending");

	// the flush cursor never passes the row's last column
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		flush_s1 |-> k_s1 <= end_s1)
		else $error("flush cursor beyond row end");

	// a row-end result closes the item when nothing new is taken
	a_row_close: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit_end && !take |=> !busy)
		else $error("item still pending after row end result");

	// a filtered result only ever goes out ahead of its flush
	a_norm_first: assert property (@(posedge clk) disable iff (!arst_n)
		fire && norm_s1 && !take |=> !norm_s1)
		else $error("filtered result issued twice");
`endif

endmodule

@@ rtl/lane_marking_row_filter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lane_marking_row_filter_core
// Dark-light-dark lane-marking filter over image rows in raster order.
//
//   channel  dir  handshake    payload
//   pix      in   valid/ready  pixel[7:0], frame_start
//   res      out  valid/ready  marked[7:0], out_column[11:0], row_end
//   cfg      in   cfg_we       cfg_index[1:0], cfg_data[12:0]
//
// One pixel per cycle is accepted while the output can load; a pixel that
// causes one result or none leaves input open. The pixel that ends a row
// issues up to w+1 results (w = marking width) from the item stage, one per
// cycle while the output accepts; input waits until the last one goes out.
// Reset clears counters and config to defaults; the pixel history memory is
// not cleared, since a tap is only used once this row has written it.
// A stalled output holds its item while the next result waits in the stage.
// ----------------------------------------------------------------------------
module lane_marking_row_filter_core import lmrf_pkg::*; #(
	parameter int MAX_MARKING_WIDTH = 63,
	parameter int MAX_COLUMNS       = 4096,
	parameter int MAX_ROWS          = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	lmrf_pix_if.sink         pix,
	lmrf_res_if.source       res,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;
	logic [MW_W-1:0]  marking_width_q;
	logic [PIX_W-1:0] edge_threshold_q;
	logic [MW_W-1:0]  mw_eff;
	logic [PIX_W-1:0] ctr_s1;
	logic [PIX_W-1:0] lft_s1;
	logic             take;
	item_ctl_t        ctl;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= FRAME_WIDTH_RST;
			frame_height_q   <= FRAME_HEIGHT_RST;
			marking_width_q  <= MARKING_WIDTH_RST;
			edge_threshold_q <= EDGE_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH:    frame_width_q    <= cfg_data;
				CFG_FRAME_HEIGHT:   frame_height_q   <= cfg_data;
				CFG_MARKING_WIDTH:  marking_width_q  <= cfg_data[MW_W-1:0];
				CFG_EDGE_THRESHOLD: edge_threshold_q <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// saturated marking width
	always_comb begin
		if (marking_width_q == '0) begin
			mw_eff = MW_W'(1);
		end else if (marking_width_q > MW_W'(MAX_MARKING_WIDTH)) begin
			mw_eff = MW_W'(MAX_MARKING_WIDTH);
		end else begin
			mw_eff = marking_width_q;
		end
	end

	assign take = pix.valid && pix.ready;

	lmrf_window_mem #(
		.MAX_MARKING_WIDTH(MAX_MARKING_WIDTH)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.pixel  (pix.pixel),
		.mwidth (mw_eff),
		.ctr_s1 (ctr_s1),
		.lft_s1 (lft_s1)
	);

	lmrf_pos_track #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.frame_start  (pix.frame_start),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.mwidth       (mw_eff),
		.ctl          (ctl)
	);

	lmrf_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.ctl       (ctl),
		.pixel     (pix.pixel),
		.ctr_s1    (ctr_s1),
		.lft_s1    (lft_s1),
		.threshold (edge_threshold_q),
		.res       (res)
	);

endmodule
